// ----- rtl/uiht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiht_pkg
// Shared widths, status and action codes for the user id hash table.
// ----------------------------------------------------------------------------
package uiht_pkg;

   localparam int ID_W     = 32;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // Low id bits form the tag, high id bits pick the bucket.
   localparam int TAG_BITS    = 22;
   localparam int TOP_W       = ID_W - TAG_BITS;
   localparam int BUCKET_SPAN = 1 << TOP_W;

   localparam int DEF_BUCKET_COUNT = 1024;
   localparam int DEF_WAYS         = 4;

   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ----- rtl/uiht_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uiht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/user_id_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// user_id_hash_table
// Bucketed table from 32-bit user id to a peer IPv4 address and port.
// ----------------------------------------------------------------------------
// One request at a time. The bucket number is reduced modulo BUCKET_COUNT:
// a constant reciprocal multiply first gives the quotient, then a
// multiply-back and subtract gives the remainder. The RAM read port then
// reads the bucket's slots one way at a time, each way a read step then a
// compare step, stopping at the first tag hit; an insert or remove writes its
// slot in the final compare step. rsp_valid is registered and rises once the
// final compare is done. The next request can transfer in the cycle after the
// response transfer; no new request is taken while one is in progress.
// After reset the block clears min(BUCKET_COUNT, 1024) * WAYS slots, one per
// cycle (4096 slots at default sizes), and holds req_stall meanwhile.
module user_id_hash_table
   import uiht_pkg::*;
#(
   parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
   parameter int WAYS         = DEF_WAYS
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ID_W-1:0]     req_user_id,
   input  logic [ADDR_W-1:0]   req_peer_address,
   input  logic [PORT_W-1:0]   req_peer_port,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_found_address,
   output logic [PORT_W-1:0]   rsp_found_port
);

   localparam int USED_ROWS = (BUCKET_COUNT < BUCKET_SPAN) ? BUCKET_COUNT : BUCKET_SPAN;
   localparam int DEPTH     = USED_ROWS * WAYS;
   localparam int SLOT_AW   = $clog2(DEPTH);
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   // Below BUCKET_SPAN buckets alias, so the whole id is kept as the tag.
   localparam int TAG_W     = (BUCKET_COUNT >= BUCKET_SPAN) ? TAG_BITS : ID_W;
   localparam int WORD_W    = 1 + TAG_W + ADDR_W + PORT_W;
   localparam int BKT_W     = $clog2(BUCKET_COUNT + 1);
   localparam int BKT_L     = $clog2(BUCKET_COUNT);
   // Rounded-up reciprocal, exact for every TOP_W-bit bucket field.
   localparam int RCP_SHIFT = TOP_W + BKT_L;
   localparam int RCP_MUL   = ((1 << RCP_SHIFT) + BUCKET_COUNT - 1) / BUCKET_COUNT;
   localparam int RCP_W     = TOP_W + 2;
   localparam int PROD_W    = TOP_W + RCP_W;
   localparam int QB_W      = TOP_W + BKT_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_REDUCE = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [SLOT_AW-1:0]  clr_ff, clr_in;

   logic [ACTION_W-1:0] action_ff, action_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [ADDR_W-1:0]   paddr_ff, paddr_in;
   logic [PORT_W-1:0]   pport_ff, pport_in;
   logic [TOP_W-1:0]    rem_ff, rem_in;
   logic [TOP_W-1:0]    quot_ff, quot_in;
   logic                step_ff, step_in;
   logic [SLOT_AW-1:0]  base_ff, base_in;
   logic [WAY_W-1:0]    way_ff, way_in;
   logic                free_found_ff, free_found_in;
   logic [WAY_W-1:0]    free_way_ff, free_way_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   faddr_ff, faddr_in;
   logic [PORT_W-1:0]   fport_ff, fport_in;

   logic                mem_we;
   logic [SLOT_AW-1:0]  mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [SLOT_AW-1:0]  mem_raddr;
   logic [WORD_W-1:0]   mem_rdata;

   logic [PROD_W-1:0]   rcp_prod;
   logic [QB_W-1:0]     quot_back;
   logic [TOP_W-1:0]    rem_red;
   logic                rd_valid;
   logic [TAG_W-1:0]    rd_tag;
   logic                hit_now;
   logic                last_way;
   logic                free_any;
   logic [WAY_W-1:0]    free_sel;
   logic                req_xfer;
   logic                rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Quotient by reciprocal multiply, then remainder by multiply-back.
   assign rcp_prod  = PROD_W'(rem_ff) * PROD_W'(RCP_MUL);
   assign quot_back = QB_W'(quot_ff) * QB_W'(BUCKET_COUNT);
   assign rem_red   = rem_ff - TOP_W'(quot_back);

   assign rd_valid = mem_rdata[WORD_W-1];
   assign rd_tag   = mem_rdata[ADDR_W+PORT_W +: TAG_W];
   assign hit_now  = rd_valid && (rd_tag == id_ff[TAG_W-1:0]);
   assign last_way = hit_now || (way_ff == WAY_W'(WAYS - 1));
   assign free_any = free_found_ff || !rd_valid;
   assign free_sel = free_found_ff ? free_way_ff : way_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      action_in     = action_ff;
      id_in         = id_ff;
      paddr_in      = paddr_ff;
      pport_in      = pport_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      base_in       = base_ff;
      way_in        = way_ff;
      free_found_in = free_found_ff;
      free_way_in   = free_way_ff;
      status_in     = status_ff;
      faddr_in      = faddr_ff;
      fport_in      = fport_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = base_ff + SLOT_AW'(way_ff);

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               action_in = req_action;
               id_in     = req_user_id;
               paddr_in  = req_peer_address;
               pport_in  = req_peer_port;
               rem_in    = req_user_id[ID_W-1 -: TOP_W];
               step_in   = 1'b1;
               state_in  = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (step_ff) begin
               quot_in = TOP_W'(rcp_prod >> RCP_SHIFT);
               step_in = 1'b0;
            end else begin
               base_in       = SLOT_AW'(rem_red) * SLOT_AW'(WAYS);
               way_in        = '0;
               free_found_in = 1'b0;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!rd_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_way_in   = way_ff;
            end
            if (last_way) begin
               status_in = ST_NOT_FOUND;
               faddr_in  = '0;
               fport_in  = '0;
               case (action_ff)
                  ACT_LOOKUP: begin
                     if (hit_now) begin
                        status_in = ST_OK;
                        faddr_in  = mem_rdata[PORT_W +: ADDR_W];
                        fport_in  = mem_rdata[PORT_W-1:0];
                     end
                  end
                  ACT_INSERT: begin
                     if (hit_now) begin
                        status_in = ST_EXISTS;
                     end else if (free_any) begin
                        status_in = ST_OK;
                        mem_we    = 1'b1;
                        mem_waddr = base_ff + SLOT_AW'(free_sel);
                        mem_wdata = {1'b1, id_ff[TAG_W-1:0], paddr_ff, pport_ff};
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  ACT_REMOVE: begin
                     if (hit_now) begin
                        status_in = ST_OK;
                        mem_we    = 1'b1;
                        mem_waddr = base_ff + SLOT_AW'(way_ff);
                        mem_wdata = '0;
                     end
                  end
                  default: begin
                     status_in = ST_NOT_FOUND;
                  end
               endcase
               state_in = S_RESP;
            end else begin
               way_in   = way_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (rsp_xfer) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      id_ff         <= id_in;
      paddr_ff      <= paddr_in;
      pport_ff      <= pport_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      base_ff       <= base_in;
      way_ff        <= way_in;
      free_found_ff <= free_found_in;
      free_way_ff   <= free_way_in;
      status_ff     <= status_in;
      faddr_ff      <= faddr_in;
      fport_ff      <= fport_in;
   end

   uiht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH),
      .AW    (SLOT_AW)
   ) u_slots (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_status        = status_ff;
   assign rsp_found_address = faddr_ff;
   assign rsp_found_port    = fport_ff;

`ifndef NO_ASSERTIONS
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken during reset or clear");

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("slot RAM read and written in one cycle");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("second request taken while one is in progress");

   a_zero_data_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_found_address == '0 && rsp_found_port == '0))
      else $error("result data not zero on a non-ok status");

   a_write_only_in_check: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || (state_ff == S_CHECK && last_way)))
      else $error("slot RAM written outside clear or final compare");
`endif

endmodule
